// File: rtl/core/icopl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package icopl_pkg;

    // fixed-point format of section state
    localparam int FRAC_BITS   = 16;

    // configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int COEF_W      = 16;
    localparam int STG_FIELD_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COEF   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_STAGES = 2'd1;

    // coefficient limits, Q0.16 (0.00005 and 0.8)
    localparam logic [COEF_W-1:0] COEF_MIN   = 16'd3;
    localparam logic [COEF_W-1:0] COEF_MAX   = 16'd52429;
    localparam logic [COEF_W-1:0] COEF_RESET = 16'd3;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_HOLD
    } t_state;

    // per-cycle commands to the lanes
    typedef struct packed {
        logic load;   // take new sample into the running value
        logic mul;    // register alpha * (prev - z[k])
        logic acc;    // z[k] += product >>> 16, prev <= new z[k]
    } t_lane_ctl;

endpackage

`default_nettype wire

// File: rtl/core/icopl_smp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface icopl_smp_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] i_sample;
    logic signed [SAMPLE_BITS-1:0] q_sample;

    modport source (output valid, output i_sample, output q_sample, input ready);
    modport sink   (input valid, input i_sample, input q_sample, output ready);
endinterface

`default_nettype wire

// File: rtl/core/icopl_flt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface icopl_flt_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] i_filtered;
    logic signed [SAMPLE_BITS-1:0] q_filtered;

    modport source (output valid, output i_filtered, output q_filtered, input ready);
    modport sink   (input valid, input i_filtered, input q_filtered, output ready);
endinterface

`default_nettype wire

// File: rtl/core/iq_cascaded_one_pole_lowpass.sv
`timescale 1ns / 1ps
`default_nettype none

// Complex cascaded one-pole low-pass. Each item is one I/Q sample; each lane
// runs it through 1..MAX_SECTIONS identical sections z += alpha*(prev - z),
// state signed Q16.16, product floored by an arithmetic shift of 16, result
// the integer part of the last active section. Both lanes share alpha
// (register 0, Q0.16, saturated to 3..52429) and the section count
// (register 1, saturated to 1..MAX_SECTIONS). Each lane has one multiplier
// that is stepped over the sections: ST_MUL registers the product and ST_ACC
// accumulates it. ST_IDLE takes the sample and ST_HOLD hands the result to
// the output register, waiting while that register holds an unread result.
// No new item is taken until the last one has left ST_HOLD. The output
// register lets the next item in while a result waits. Section state is
// cleared by reset; inactive sections keep their values.
module iq_cascaded_one_pole_lowpass
    import icopl_pkg::*;
#(
    parameter int MAX_SECTIONS = 4,
    parameter int SAMPLE_BITS  = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    icopl_smp_if.sink                  i_smp,
    icopl_flt_if.source                o_flt
);

    localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int STG_W = $clog2(MAX_SECTIONS + 1);
    localparam int CMP_W = (STG_W > STG_FIELD_W) ? STG_W : STG_FIELD_W;

    // config registers
    logic [COEF_W-1:0] r_coef;
    logic [STG_W-1:0]  r_stages;
    logic [COEF_W-1:0] n_coef;
    logic [STG_W-1:0]  n_stages;
    logic [CMP_W-1:0]  s_stg_raw;

    always_comb begin
        n_coef = i_cfg_data[COEF_W-1:0];
        if (n_coef < COEF_MIN) begin
            n_coef = COEF_MIN;
        end else if (n_coef > COEF_MAX) begin
            n_coef = COEF_MAX;
        end

        s_stg_raw = CMP_W'(i_cfg_data[STG_FIELD_W-1:0]);
        priority if (s_stg_raw == '0) begin
            n_stages = STG_W'(1);
        end else if (s_stg_raw > CMP_W'(MAX_SECTIONS)) begin
            n_stages = STG_W'(MAX_SECTIONS);
        end else begin
            n_stages = STG_W'(s_stg_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef   <= COEF_RESET;
            r_stages <= STG_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_IDX_COEF) begin
                r_coef <= n_coef;
            end
            if (i_cfg_idx == CFG_IDX_STAGES) begin
                r_stages <= n_stages;
            end
        end
    end

    // sequencer: one section per MUL/ACC pair, shared by both lanes
    t_state           r_state;
    t_state           n_state;
    logic [SEC_W-1:0] r_sec;
    logic             s_last;
    logic             s_accept;
    logic             s_free;
    logic             s_done;
    t_lane_ctl        s_ctl;

    assign s_last   = (STG_W'(r_sec) + STG_W'(1)) == r_stages;
    assign s_accept = i_smp.valid && i_smp.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_smp.valid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_state = s_last ? ST_HOLD : ST_MUL;
            end
            ST_HOLD: begin
                if (s_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        i_smp.ready = 1'b0;
        s_ctl       = '0;
        s_done      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_smp.ready = 1'b1;
                s_ctl.load  = i_smp.valid;
            end
            ST_MUL: begin
                s_ctl.mul = 1'b1;
            end
            ST_ACC: begin
                s_ctl.acc = 1'b1;
            end
            ST_HOLD: begin
                s_done = s_free;
            end
            default: begin
                s_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sec   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) begin
                r_sec <= '0;
            end else if (r_state == ST_ACC && !s_last) begin
                r_sec <= r_sec + SEC_W'(1);
            end
        end
    end

    // lanes
    logic signed [SAMPLE_BITS-1:0] s_i_res;
    logic signed [SAMPLE_BITS-1:0] s_q_res;

    icopl_lane #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_lane_i (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (s_ctl),
        .i_sec    (r_sec),
        .i_coef   (r_coef),
        .i_sample (i_smp.i_sample),
        .o_result (s_i_res)
    );

    icopl_lane #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_lane_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (s_ctl),
        .i_sec    (r_sec),
        .i_coef   (r_coef),
        .i_sample (i_smp.q_sample),
        .o_result (s_q_res)
    );

    // pairs the lane results into one item
    icopl_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s_done),
        .i_i_res (s_i_res),
        .i_q_res (s_q_res),
        .o_free  (s_free),
        .o_flt   (o_flt)
    );

    // checks
    a_sec_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL || r_state == ST_ACC) |-> (STG_W'(r_sec) < r_stages))
        else $error("section index beyond active count");

    a_stages_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stages != '0) && (r_stages <= STG_W'(MAX_SECTIONS)))
        else $error("stage count outside 1..MAX_SECTIONS");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_flt.valid && !o_flt.ready) |=> !$fell(o_flt.valid) && $stable(o_flt.i_filtered))
        else $error("pending result overwritten or dropped");

    a_accept_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == ST_MUL) && (r_sec == '0))
        else $error("accepted item did not start at first section");

endmodule

`default_nettype wire

// File: rtl/core/icopl_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module icopl_lane
    import icopl_pkg::*;
#(
    parameter int SAMPLE_BITS  = 16,
    parameter int MAX_SECTIONS = 4,
    localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_lane_ctl                     i_ctl,
    input  wire logic [SEC_W-1:0]              i_sec,
    input  wire logic [COEF_W-1:0]             i_coef,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [SAMPLE_BITS-1:0]      o_result
);

    localparam int ST_W = SAMPLE_BITS + FRAC_BITS;
    localparam int PW   = ST_W + 1 + COEF_W + 1;

    logic signed [ST_W-1:0] r_z [MAX_SECTIONS];
    logic signed [ST_W-1:0] r_prev;
    logic signed [PW-1:0]   r_prod;

    logic signed [ST_W:0]     s_diff;
    logic signed [PW-1:0]     n_prod;
    logic signed [ST_W-1:0]   n_z;

    always_comb begin
        s_diff = (ST_W+1)'(r_prev) - (ST_W+1)'(r_z[i_sec]);
        n_prod = PW'(s_diff) * PW'($signed({1'b0, i_coef}));
        // floor shift is the arithmetic shift, taken as a part-select
        n_z    = r_z[i_sec] + $signed(r_prod[FRAC_BITS +: ST_W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < MAX_SECTIONS; s++) begin
                r_z[s] <= '0;
            end
        end else if (i_ctl.acc) begin
            r_z[i_sec] <= n_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_prev <= {i_sample, {FRAC_BITS{1'b0}}};
        end else if (i_ctl.acc) begin
            r_prev <= n_z;
        end
        if (i_ctl.mul) begin
            r_prod <= n_prod;
        end
    end

    // integer part of the last updated section
    assign o_result = r_prev[ST_W-1:FRAC_BITS];

endmodule

`default_nettype wire

// File: rtl/core/icopl_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module icopl_merge
    import icopl_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire logic signed [SAMPLE_BITS-1:0] i_i_res,
    input  wire logic signed [SAMPLE_BITS-1:0] i_q_res,
    output logic                               o_free,
    icopl_flt_if.source                        o_flt
);

    logic                          r_valid;
    logic signed [SAMPLE_BITS-1:0] r_i;
    logic signed [SAMPLE_BITS-1:0] r_q;

    assign o_free = !r_valid || o_flt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_flt.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_i <= i_i_res;
            r_q <= i_q_res;
        end
    end

    assign o_flt.valid      = r_valid;
    assign o_flt.i_filtered = r_i;
    assign o_flt.q_filtered = r_q;

endmodule

`default_nettype wire
